/* design/utf8d_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`default_nettype none

package utf8d_pkg;

    localparam int unsigned FIFO_DEPTH = 2;
    localparam logic [15:0] REPL_RESET = 16'hFFFD;

    // Back-end command: leading replacements, then an optional tail unit.
    typedef struct packed {
        logic [1:0]  nbad;
        logic        tail_valid;
        logic        tail_bad;
        logic [15:0] tail_unit;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

`default_nettype wire

/* design/utf8d_front.sv */
// Front end: accepts bytes, tracks the open sequence and builds back-end commands.
`default_nettype none

module utf8d_front (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [7:0]             s_data_byte,
    input  wire logic                   s_end_of_input,
    input  wire utf8d_pkg::fifo_status_t fifo_status,
    output logic                        push,
    output utf8d_pkg::cmd_t             cmd
);

    logic [1:0]  needed_reg, needed_next;
    logic [1:0]  held_reg, held_next;
    logic [15:0] partial_reg, partial_next;
    logic        four_reg, four_next;

    logic        accept;
    logic        fresh;
    logic        is_lead;
    logic [15:0] partial_shift;

    assign s_ready = !fifo_status.full;
    assign accept  = s_valid && s_ready;
    assign partial_shift = {partial_reg[9:0], s_data_byte[5:0]};

    always_comb begin
        needed_next  = needed_reg;
        held_next    = held_reg;
        partial_next = partial_reg;
        four_next    = four_reg;
        cmd          = '0;
        fresh        = 1'b0;
        is_lead      = 1'b0;

        if (needed_reg == 2'd0) begin
            fresh = 1'b1;
        end else if (s_data_byte[7:6] == 2'b10) begin
            partial_next = partial_shift;
            held_next    = held_reg + 2'd1;
            needed_next  = needed_reg - 2'd1;
            if (needed_reg == 2'd1) begin
                cmd.tail_valid = 1'b1;
                cmd.tail_bad   = four_reg;
                cmd.tail_unit  = partial_shift;
                needed_next    = 2'd0;
                held_next      = 2'd0;
                partial_next   = '0;
                four_next      = 1'b0;
            end else if (s_end_of_input) begin
                cmd.tail_valid = 1'b1;
                cmd.tail_bad   = 1'b1;
                needed_next    = 2'd0;
                held_next      = 2'd0;
                partial_next   = '0;
                four_next      = 1'b0;
            end
        end else begin
            // broken sequence: one replacement for the lead and one per held continuation, at most three
            cmd.nbad = (held_reg >= 2'd2) ? 2'd3 : held_reg + 2'd1;
            fresh    = 1'b1;
        end

        if (fresh) begin
            needed_next  = 2'd0;
            held_next    = 2'd0;
            partial_next = '0;
            four_next    = 1'b0;
            if (s_data_byte < 8'h80) begin
                cmd.tail_valid = 1'b1;
                cmd.tail_unit  = {8'h00, s_data_byte};
            end else if (s_data_byte inside {[8'hC2:8'hDF]}) begin
                is_lead      = 1'b1;
                needed_next  = 2'd1;
                partial_next = {11'b0, s_data_byte[4:0]};
            end else if (s_data_byte inside {[8'hE0:8'hEF]}) begin
                is_lead      = 1'b1;
                needed_next  = 2'd2;
                partial_next = {12'b0, s_data_byte[3:0]};
            end else if (s_data_byte inside {[8'hF0:8'hF4]}) begin
                is_lead      = 1'b1;
                needed_next  = 2'd3;
                partial_next = {13'b0, s_data_byte[2:0]};
                four_next    = 1'b1;
            end else begin
                cmd.tail_valid = 1'b1;
                cmd.tail_bad   = 1'b1;
            end
            if (is_lead && s_end_of_input) begin
                cmd.tail_valid = 1'b1;
                cmd.tail_bad   = 1'b1;
                needed_next    = 2'd0;
                partial_next   = '0;
                four_next      = 1'b0;
            end
        end
    end

    assign push = accept && ((cmd.nbad != 2'd0) || cmd.tail_valid);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needed_reg  <= 2'd0;
            held_reg    <= 2'd0;
            partial_reg <= '0;
            four_reg    <= 1'b0;
        end else if (accept) begin
            needed_reg  <= needed_next;
            held_reg    <= held_next;
            partial_reg <= partial_next;
            four_reg    <= four_next;
        end
    end

endmodule

`default_nettype wire

/* design/utf8d_fifo.sv */
// Short command queue between front and back end.
`default_nettype none

module utf8d_fifo (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire utf8d_pkg::cmd_t         push_cmd,
    input  wire logic                    pop,
    output utf8d_pkg::cmd_t              head_cmd,
    output utf8d_pkg::fifo_status_t      status
);

    localparam int unsigned PTR_W = (utf8d_pkg::FIFO_DEPTH > 1) ?
                                    $clog2(utf8d_pkg::FIFO_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(utf8d_pkg::FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(utf8d_pkg::FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(utf8d_pkg::FIFO_DEPTH);

    utf8d_pkg::cmd_t  entry_reg [utf8d_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign head_cmd     = entry_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/utf8d_back.sv */
// Back end: expands each command into code units through the output register.
`default_nettype none

module utf8d_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire utf8d_pkg::cmd_t  head_cmd,
    input  wire logic             fifo_empty,
    input  wire logic [15:0]      repl_unit,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [15:0]           m_code_unit,
    output logic                  m_was_invalid,
    output logic                  m_run_last
);

    logic [1:0]  cnt_reg, cnt_next;
    logic        m_valid_reg, m_valid_next;
    logic [15:0] unit_reg;
    logic        invalid_reg;
    logic        last_reg;

    logic [2:0]  total;
    logic        is_last;
    logic        use_tail;
    logic        load;

    assign total    = {1'b0, head_cmd.nbad} + {2'b00, head_cmd.tail_valid};
    assign is_last  = ({1'b0, cnt_reg} == (total - 3'd1));
    assign use_tail = (cnt_reg >= head_cmd.nbad) && !head_cmd.tail_bad;
    assign load     = !fifo_empty && (!m_valid_reg || m_ready);
    assign pop      = load && is_last;

    always_comb begin
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            cnt_next     = is_last ? 2'd0 : cnt_reg + 2'd1;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            unit_reg    <= use_tail ? head_cmd.tail_unit : repl_unit;
            invalid_reg <= !use_tail;
            last_reg    <= is_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_code_unit   = unit_reg;
    assign m_was_invalid = invalid_reg;
    assign m_run_last    = last_reg;

endmodule

`default_nettype wire

/* design/utf8_to_utf16_decoder_top.sv */
// Top level of the UTF-8 to UTF-16 (BMP) decoder.
`default_nettype none

// Takes one UTF-8 byte per clock while the command queue has room, and returns
// 16-bit code units, one per clock on the result channel while m_ready is high. A
// byte may yield no unit, or n units (up to four on a broken sequence) that hold
// the back end while they are sent, and a two-entry command queue between the front
// end and the back end lets the input keep flowing during such bursts while it has room.
// The replacement unit resets to 0xFFFD; the user must write it through the cfg
// channel only while the decoder is idle, and the block itself does not enforce this.
module utf8_to_utf16_decoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_input,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_code_unit,
    output logic             m_was_invalid,
    output logic             m_run_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    logic [15:0]             repl_reg;
    logic                    push;
    logic                    pop;
    utf8d_pkg::cmd_t         push_cmd;
    utf8d_pkg::cmd_t         head_cmd;
    utf8d_pkg::fifo_status_t fifo_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repl_reg <= utf8d_pkg::REPL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            repl_reg <= cfg_data;
        end
    end

    utf8d_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_end_of_input (s_end_of_input),
        .fifo_status    (fifo_status),
        .push           (push),
        .cmd            (push_cmd)
    );

    utf8d_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (fifo_status)
    );

    utf8d_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_cmd      (head_cmd),
        .fifo_empty    (fifo_status.empty),
        .repl_unit     (repl_reg),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_unit   (m_code_unit),
        .m_was_invalid (m_was_invalid),
        .m_run_last    (m_run_last)
    );

`ifndef SYNTHESIS
    a_fifo_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_status.full && fifo_status.empty))
        else $error("queue reports full and empty together");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !fifo_status.full)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fifo_status.empty)
        else $error("command popped from empty queue");

    a_good_unit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_was_invalid) |-> m_run_last)
        else $error("decoded unit not marked as last of its byte");
`endif

endmodule

`default_nettype wire

/* sim/utf8_unit_checker.sv */
// Checker for the UTF-8 to UTF-16 decoder: predicts code units per byte and compares results.
module utf8_unit_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_input,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [15:0] m_code_unit,
    input  wire logic        m_was_invalid,
    input  wire logic        m_run_last,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [15:0] cfg_data,
    output int unsigned      pending_units,
    output int unsigned      fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PRINT_CAP = 20;

    typedef struct packed {
        logic [15:0] unit;
        logic        bad;
        logic        last;
    } unit_rec_t;

    unit_rec_t   due_units[$];
    unit_rec_t   step_units[$];
    int unsigned mismatch_total = 0;

    logic [15:0] repl_unit;
    logic [1:0]  need_cnt;
    logic [1:0]  held_cnt;
    logic [20:0] acc_point;
    logic        four_lead;

    task automatic flag_mismatch(input string msg);
        if (mismatch_total < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    function automatic void add_unit(input logic [15:0] u, input logic bad);
        unit_rec_t rec;
        rec.unit = u;
        rec.bad  = bad;
        rec.last = 1'b0;
        step_units.push_back(rec);
    endfunction

    function automatic void clear_seq();
        need_cnt  = 2'd0;
        held_cnt  = 2'd0;
        acc_point = '0;
        four_lead = 1'b0;
    endfunction

    function automatic void open_seq(input logic [7:0] din, input logic eoi);
        if (din < 8'h80) begin
            add_unit({8'h00, din}, 1'b0);
            return;
        end
        if (din >= 8'hC2 && din <= 8'hDF) begin
            need_cnt  = 2'd1;
            acc_point = {16'd0, din[4:0]};
        end else if (din >= 8'hE0 && din <= 8'hEF) begin
            need_cnt  = 2'd2;
            acc_point = {17'd0, din[3:0]};
        end else if (din >= 8'hF0 && din <= 8'hF4) begin
            need_cnt  = 2'd3;
            acc_point = {18'd0, din[2:0]};
            four_lead = 1'b1;
        end else begin
            add_unit(repl_unit, 1'b1);
            return;
        end
        held_cnt = 2'd0;
        if (eoi) begin
            add_unit(repl_unit, 1'b1);
            clear_seq();
        end
    endfunction

    // One accepted input byte -> zero to four expected code units.
    function automatic void decode_byte(input logic [7:0] din, input logic eoi);
        logic [1:0] held_now;
        step_units.delete();
        if (need_cnt == 2'd0) begin
            open_seq(din, eoi);
        end else if (din[7:6] == 2'b10) begin
            acc_point = {acc_point[14:0], din[5:0]};
            held_cnt  = held_cnt + 2'd1;
            need_cnt  = need_cnt - 2'd1;
            if (need_cnt == 2'd0) begin
                if (four_lead || acc_point > 21'h00FFFF)
                    add_unit(repl_unit, 1'b1);
                else
                    add_unit(acc_point[15:0], 1'b0);
                clear_seq();
            end else if (eoi) begin
                add_unit(repl_unit, 1'b1);
                clear_seq();
            end
        end else begin
            held_now = held_cnt;
            add_unit(repl_unit, 1'b1);
            for (int i = 0; i < held_now && i < 2; i++)
                add_unit(repl_unit, 1'b1);
            clear_seq();
            open_seq(din, eoi);
        end
        if (step_units.size() > 0)
            step_units[step_units.size() - 1].last = 1'b1;
        foreach (step_units[i])
            due_units.push_back(step_units[i]);
    endfunction

    always @(posedge aclk) begin : monitor
        unit_rec_t want;
        if (!aresetn) begin
            repl_unit = utf8d_pkg::REPL_RESET;
            clear_seq();
            due_units.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                repl_unit = cfg_data;
            if (s_valid && s_ready)
                decode_byte(s_data_byte, s_end_of_input);
            if (m_valid && m_ready) begin
                if (due_units.size() == 0) begin
                    flag_mismatch($sformatf("unexpected unit %h invalid %b last %b",
                                            m_code_unit, m_was_invalid, m_run_last));
                end else begin
                    want = due_units.pop_front();
                    if (m_code_unit !== want.unit)
                        flag_mismatch($sformatf("code_unit %h, predicted %h",
                                                m_code_unit, want.unit));
                    if (m_was_invalid !== want.bad)
                        flag_mismatch($sformatf("was_invalid %b, predicted %b (unit %h)",
                                                m_was_invalid, want.bad, want.unit));
                    if (m_run_last !== want.last)
                        flag_mismatch($sformatf("run_last %b, predicted %b (unit %h)",
                                                m_run_last, want.last, want.unit));
                end
            end
        end
        pending_units <= due_units.size();
        fail_count    <= mismatch_total;
    end

endmodule

/* sim/tb_top.sv */
// Testbench top for the UTF-8 to UTF-16 decoder: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_PCT       = 37;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned EOI_PCT        = 3;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte    = 8'h00;
    logic        s_end_of_input = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [15:0] m_code_unit;
    logic        m_was_invalid;
    logic        m_run_last;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data       = 16'h0000;

    int unsigned pending_units;
    int unsigned fail_count;
    int unsigned src_idle_pct   = IDLE_PCT;
    int unsigned sink_idle_pct  = IDLE_PCT;
    int unsigned bytes_sent     = 0;
    int unsigned quiet_cycles   = 0;

    // {end_of_input, byte}
    logic [8:0] directed_seq [] = '{
        9'h000, 9'h07F,
        9'h0C2, 9'h080, 9'h0DF, 9'h0BF,
        9'h0E0, 9'h080, 9'h080, 9'h0EF, 9'h0BF, 9'h0BF,
        9'h0F0, 9'h090, 9'h080, 9'h080,
        9'h080, 9'h0FF,
        9'h0E2, 9'h082, 9'h041,
        9'h0F4, 9'h08F, 9'h0BF, 9'h1C3,
        9'h0E2, 9'h182,
        9'h17F
    };

    utf8_to_utf16_decoder_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code_unit    (m_code_unit),
        .m_was_invalid  (m_was_invalid),
        .m_run_last     (m_run_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    utf8_unit_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code_unit    (m_code_unit),
        .m_was_invalid  (m_was_invalid),
        .m_run_last     (m_run_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .pending_units  (pending_units),
        .fail_count     (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] din, input logic eoi);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= din;
        s_end_of_input <= eoi;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_units != 0)
            @(posedge aclk);
    endtask

    task automatic write_repl(input logic [15:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(63))};
    endfunction

    function automatic logic pick_eoi();
        return $urandom_range(99) < EOI_PCT;
    endfunction

    // One character: mostly well-formed, some broken sequences and raw noise.
    task automatic send_char();
        int unsigned kind;
        int unsigned n_cont;
        int unsigned cut;
        int unsigned r;
        logic [7:0]  lead;
        kind = $urandom_range(99);
        if (kind < 30) begin
            push_byte(8'($urandom_range(8'h7F)), pick_eoi());
        end else if (kind < 86) begin
            r = $urandom_range(2);
            n_cont = r + 1;
            case (r)
                0: lead = 8'($urandom_range(8'hDF, 8'hC2));
                1: lead = 8'($urandom_range(8'hEF, 8'hE0));
                default: lead = 8'($urandom_range(8'hF4, 8'hF0));
            endcase
            if (kind < 76) begin
                push_byte(lead, pick_eoi());
                for (int i = 0; i < n_cont; i++)
                    push_byte(cont_byte(), pick_eoi());
            end else begin
                cut = $urandom_range(n_cont - 1);
                push_byte(lead, pick_eoi());
                for (int i = 0; i < cut; i++)
                    push_byte(cont_byte(), pick_eoi());
                r = $urandom_range(191);
                push_byte((r < 128) ? 8'(r) : 8'(r + 64), pick_eoi());
            end
        end else begin
            push_byte(8'($urandom_range(255)), pick_eoi());
        end
    endtask

    task automatic run_random(input int unsigned upto, input bit hold_mid);
        int unsigned half;
        half = (bytes_sent + upto) / 2;
        while (bytes_sent < upto) begin
            send_char();
            if (hold_mid && bytes_sent >= half) begin
                wait_drained();
                hold_mid = 0;
            end
        end
        push_byte(8'h0A, 1'b1);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_seq[i])
            push_byte(directed_seq[i][7:0], directed_seq[i][8]);

        write_repl(16'h0000);
        run_random(150, 1'b1);

        write_repl(16'hFFFF);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(275, 1'b0);

        write_repl(16'($urandom_range(16'hFFFF)));
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
        run_random(380, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* utf8_to_utf16_decoder_top.f */
design/utf8d_pkg.sv
design/utf8d_front.sv
design/utf8d_fifo.sv
design/utf8d_back.sv
design/utf8_to_utf16_decoder_top.sv
sim/utf8_unit_checker.sv
sim/tb_top.sv
